[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; all sample on clk and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vrs_pkg;

	// Field widths of the command and response beats
	localparam int ACTION_W = 2;
	localparam int TYPE_W   = 8;
	localparam int SIZE_W   = 4;
	localparam int DATA_W   = 64;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 15;

	// Default geometry
	localparam int STORE_BYTES_DEF = 32768;
	localparam int MAX_PAYLOAD_DEF = 8;

	// Record header layout
	localparam int HDR_BYTES   = 11;
	localparam int LINK_BYTES  = 8;
	localparam int HDR_TYPE_AT = 8;
	localparam int HDR_SIZE_AT = 9;

	// Actions
	localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_OVF   = 2'd1;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

	// Register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int LIMIT_W = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h8000;
	localparam logic REG_STACK_LIMIT = 1'b0;

endpackage

`default_nettype wire

[rtl/vrs_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface vrs_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [vrs_pkg::ACTION_W-1:0]   action;
	logic [vrs_pkg::TYPE_W-1:0]     type_code;
	logic [vrs_pkg::SIZE_W-1:0]     payload_size;
	logic [vrs_pkg::DATA_W-1:0]     payload_data;

	modport source (output valid, action, type_code, payload_size, payload_data,
		input ready);
	modport sink (input valid, action, type_code, payload_size, payload_data,
		output ready);
endinterface

// Response channel
interface vrs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [vrs_pkg::STATUS_W-1:0]   status;
	logic [vrs_pkg::TYPE_W-1:0]     top_type;
	logic [vrs_pkg::SIZE_W-1:0]     top_size;
	logic [vrs_pkg::DATA_W-1:0]     top_data;
	logic [vrs_pkg::USED_W-1:0]     bytes_used;

	modport source (output valid, status, top_type, top_size, top_data, bytes_used,
		input ready);
	modport sink (input valid, status, top_type, top_size, top_data, bytes_used,
		output ready);
endinterface

`default_nettype wire

[rtl/variable_record_stack.sv]
// Stack of tagged variable-length records in a byte-wide store.
// Channels: cmd (sink) carries one action per beat: push, pop or peek.
// rsp (source) returns exactly one beat per command, in order.
// Register port: APB-style write/read of stack_limit at address 0.
// Timing: one command at a time; cmd.ready is high while the sequencer is idle.
// With n payload bytes and L = ceil(log2(STORE_BYTES)/8) link bytes, the
// sequencer steps through the store before the response register loads:
//   push writes one header or payload byte per cycle,
//   pop reads the L link bytes one per cycle, peek reads type, size, pad and
//   the n payload bytes; rejected push, empty pop/peek and unused action skip
//   the store. cmd.ready returns at the same edge as that load.
// A single-port byte store serves each step; a record moves one byte a cycle.
// A finished response sits in an output register, so a new command is taken
// while it waits; if rsp is stalled, the next response waits in the sequencer.
// Reset empties the stack (top and next offsets zero) and sets stack_limit to
// 32768; store contents stay undefined and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module variable_record_stack #(
	parameter int STORE_BYTES       = vrs_pkg::STORE_BYTES_DEF,
	parameter int MAX_PAYLOAD_BYTES = vrs_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	vrs_cmd_if.sink                           cmd,
	vrs_rsp_if.source                         rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vrs_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [vrs_pkg::PDATA_W-1:0]  pwdata,
	output logic      [vrs_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int LB = (AW + 7) / 8;
	localparam int CW = ((AW > vrs_pkg::LIMIT_W) ? AW : vrs_pkg::LIMIT_W) + 1;
	localparam int IW = 5;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WR   = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	localparam logic [IW-1:0] IDX_TYPE = IW'(vrs_pkg::HDR_TYPE_AT);
	localparam logic [IW-1:0] IDX_SIZE = IW'(vrs_pkg::HDR_SIZE_AT);
	localparam logic [IW-1:0] IDX_PAY  = IW'(vrs_pkg::HDR_BYTES);
	localparam logic [IW-1:0] IDX_HLAST = IW'(vrs_pkg::HDR_BYTES - 1);
	localparam logic [IW-1:0] IDX_LINKS = IW'(vrs_pkg::LINK_BYTES);
	localparam logic [IW-1:0] IDX_LB    = IW'(LB);
	localparam logic [vrs_pkg::SIZE_W-1:0] MAX_SZ = vrs_pkg::SIZE_W'(MAX_PAYLOAD_BYTES);

	logic [2:0]                      state_q;
	logic [AW-1:0]                   top_q, next_q;
	logic [vrs_pkg::LIMIT_W-1:0]     limit_q;

	// latched command
	logic [vrs_pkg::ACTION_W-1:0]    act_q;
	logic [vrs_pkg::TYPE_W-1:0]      tcode_q;
	logic [vrs_pkg::SIZE_W-1:0]      psz_q;
	logic [vrs_pkg::DATA_W-1:0]      pdata_q;

	// working results
	logic [vrs_pkg::STATUS_W-1:0]    sts_q;
	logic [vrs_pkg::TYPE_W-1:0]      otype_q;
	logic [vrs_pkg::SIZE_W-1:0]      osize_q;
	logic [vrs_pkg::DATA_W-1:0]      odata_q;
	logic [AW-1:0]                   link_q;

	// byte sequencer and read pipeline
	logic [IW-1:0]                   idx_q;
	logic                            pend_s1;
	logic [IW-1:0]                   pidx_s1;

	// output register
	logic                            rv_q;
	logic [vrs_pkg::STATUS_W-1:0]    r_sts_q;
	logic [vrs_pkg::TYPE_W-1:0]      r_type_q;
	logic [vrs_pkg::SIZE_W-1:0]      r_size_q;
	logic [vrs_pkg::DATA_W-1:0]      r_data_q;
	logic [vrs_pkg::USED_W-1:0]      r_used_q;

	// store
	logic [7:0]                      store_mem [STORE_BYTES];
	logic [7:0]                      mem_rdata_q;
	logic [AW-1:0]                   mem_addr;
	logic [7:0]                      mem_wdata;
	logic                            mem_we;

	logic                            cmd_fire;
	logic                            cfg_wr;
	logic [vrs_pkg::SIZE_W-1:0]      in_psz;
	logic [CW-1:0]                   eff_limit;
	logic                            overflow;
	logic                            is_empty;
	logic                            rd_more;
	logic                            wr_last;
	logic                            out_free;
	logic [vrs_pkg::DATA_W-1:0]      link64;
	logic [vrs_pkg::DATA_W-1:0]      pay_sh;
	logic [vrs_pkg::DATA_W-1:0]      rd_sh;
	logic [2:0]                      wr_pi;
	logic [2:0]                      rd_pi;
	logic [IW-1:0]                   rd_poff;
	logic [vrs_pkg::SIZE_W-1:0]      rd_size_sat;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_free = !rv_q || rsp.ready;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == vrs_pkg::REG_STACK_LIMIT);
	assign prdata = (paddr[2] == vrs_pkg::REG_STACK_LIMIT) ?
		vrs_pkg::PDATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= vrs_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[vrs_pkg::LIMIT_W-1:0];
		end
	end

	// Clamp size and check room for a new record
	assign in_psz = (cmd.payload_size > MAX_SZ) ? MAX_SZ : cmd.payload_size;
	assign eff_limit = (CW'(limit_q) < CW'(STORE_BYTES)) ? CW'(limit_q) : CW'(STORE_BYTES);
	assign overflow = (CW'(next_q) + CW'(vrs_pkg::HDR_BYTES) + CW'(in_psz)) >= eff_limit;
	assign is_empty = (top_q == next_q);

	// Write byte for a push: link, type, size, zero, payload
	assign link64 = vrs_pkg::DATA_W'(top_q) >> {idx_q[2:0], 3'b000};
	assign wr_pi  = 3'(idx_q - IDX_PAY);
	assign pay_sh = pdata_q >> {wr_pi, 3'b000};
	always_comb begin
		if (idx_q < IDX_LINKS) begin
			mem_wdata = link64[7:0];
		end else if (idx_q == IDX_TYPE) begin
			mem_wdata = tcode_q;
		end else if (idx_q == IDX_SIZE) begin
			mem_wdata = 8'(psz_q);
		end else if (idx_q == IDX_HLAST) begin
			mem_wdata = 8'h00;
		end else begin
			mem_wdata = pay_sh[7:0];
		end
	end
	assign wr_last = (idx_q == (IDX_HLAST + IW'(psz_q)));

	// Read issue: pop walks the link bytes, peek walks type, size, pad, payload
	always_comb begin
		if (act_q == vrs_pkg::ACT_POP) begin
			rd_more = idx_q < IDX_LB;
		end else begin
			rd_more = (idx_q <= IDX_HLAST) || ((idx_q - IDX_PAY) < IW'(osize_q));
		end
	end

	assign mem_we   = (state_q == ST_WR);
	assign mem_addr = (state_q == ST_WR) ? AW'(next_q + AW'(idx_q)) : AW'(top_q + AW'(idx_q));

	// Byte store, one access per cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_addr] <= mem_wdata;
		end
		mem_rdata_q <= store_mem[mem_addr];
	end

	// Returned byte placement
	assign rd_poff = pidx_s1 - IDX_PAY;
	assign rd_pi   = rd_poff[2:0];
	assign rd_sh   = vrs_pkg::DATA_W'(mem_rdata_q) << {pidx_s1[2:0], 3'b000};
	assign rd_size_sat = (mem_rdata_q > 8'(MAX_SZ)) ? MAX_SZ : mem_rdata_q[vrs_pkg::SIZE_W-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q   <= '0;
			next_q  <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						idx_q <= (cmd.action == vrs_pkg::ACT_PEEK) ? IDX_TYPE : '0;
						if (cmd.action == vrs_pkg::ACT_PUSH) begin
							state_q <= overflow ? ST_DONE : ST_WR;
						end else if (cmd.action == vrs_pkg::ACT_POP) begin
							state_q <= is_empty ? ST_DONE : ST_RD;
						end else if (cmd.action == vrs_pkg::ACT_PEEK) begin
							state_q <= is_empty ? ST_DONE : ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WR: begin
					idx_q <= idx_q + 1'b1;
					if (wr_last) begin
						top_q   <= next_q;
						next_q  <= AW'(next_q + AW'(vrs_pkg::HDR_BYTES) + AW'(psz_q));
						state_q <= ST_DONE;
					end
				end
				ST_RD: begin
					pend_s1 <= rd_more;
					if (rd_more) begin
						idx_q <= (idx_q == IDX_SIZE && act_q == vrs_pkg::ACT_PEEK) ?
							IDX_HLAST : idx_q + 1'b1;
					end else if (!pend_s1) begin
						if (act_q == vrs_pkg::ACT_POP) begin
							next_q <= top_q;
							top_q  <= link_q;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command latch and result gathering
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			act_q   <= cmd.action;
			tcode_q <= cmd.type_code;
			psz_q   <= in_psz;
			pdata_q <= cmd.payload_data;
			otype_q <= '0;
			osize_q <= '0;
			odata_q <= '0;
			link_q  <= '0;
			if (cmd.action == vrs_pkg::ACT_PUSH && overflow) begin
				sts_q <= vrs_pkg::STS_OVF;
			end else if ((cmd.action == vrs_pkg::ACT_POP || cmd.action == vrs_pkg::ACT_PEEK)
					&& is_empty) begin
				sts_q <= vrs_pkg::STS_EMPTY;
			end else begin
				sts_q <= vrs_pkg::STS_OK;
			end
		end else if (state_q == ST_RD && pend_s1) begin
			if (act_q == vrs_pkg::ACT_POP) begin
				link_q <= link_q | rd_sh[AW-1:0];
			end else if (pidx_s1 == IDX_TYPE) begin
				otype_q <= mem_rdata_q;
			end else if (pidx_s1 == IDX_SIZE) begin
				osize_q <= rd_size_sat;
			end else if (pidx_s1 >= IDX_PAY) begin
				odata_q <= odata_q | (vrs_pkg::DATA_W'(mem_rdata_q) << {rd_pi, 3'b000});
			end
		end
		if (state_q == ST_RD) begin
			pidx_s1 <= idx_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rv_q <= 1'b1;
		end else if (rsp.ready) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			r_sts_q  <= sts_q;
			r_type_q <= otype_q;
			r_size_q <= osize_q;
			r_data_q <= odata_q;
			r_used_q <= vrs_pkg::USED_W'(next_q);
		end
	end

	assign rsp.valid      = rv_q;
	assign rsp.status     = r_sts_q;
	assign rsp.top_type   = r_type_q;
	assign rsp.top_size   = r_size_q;
	assign rsp.top_data   = r_data_q;
	assign rsp.bytes_used = r_used_q;

	`include "assert_macros.svh"

	`VRS_ASSERT_NOW(a_top_below_next, 1'b1, top_q <= next_q, "top offset above next offset")
	`VRS_ASSERT_NOW(a_write_only_push, mem_we, act_q == vrs_pkg::ACT_PUSH, "store write outside a push")
	`VRS_ASSERT_NEXT(a_busy_after_cmd, cmd_fire, state_q != ST_IDLE, "sequencer idle after a command")
	`VRS_ASSERT_NEXT(a_rsp_loads, state_q == ST_DONE && out_free, rv_q, "response not loaded")

endmodule

`default_nettype wire
